FILE: sv/gef_pkg.sv
// Shared constants, codes and types of the 3x3 gradient edge filter.
package gef_pkg;

	// Field widths fixed by the stream and register formats
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_PIX_W   = 8;
	localparam int EDGE_W     = 8;
	localparam int EDGE_MAX   = 255;

	// Frame height limits, row counter width
	localparam int MIN_SIZE   = 3;
	localparam int MAX_HEIGHT = 1024;
	localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);

	// Defaults for the top level parameters
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_PIXEL_BITS = 8;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = CFG_W'(640);
	localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = CFG_W'(480);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH    = 2'd0,
		CFG_IMAGE_HEIGHT   = 2'd1,
		CFG_EDGE_DIRECTION = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		MODE_PIXEL = 1'b0,
		MODE_FLUSH = 1'b1
	} item_mode_t;

	typedef enum logic {
		DIR_HORIZ = 1'b0,
		DIR_VERT  = 1'b1
	} edge_dir_t;

	// Per-item control handed to the kernel
	typedef struct packed {
		logic flush;   // flush item, result is zero
		logic border;  // window touches the frame border, result is zero
	} gef_ctrl_t;

endpackage

FILE: sv/gef_stream_if.sv
// Valid/ready stream interfaces for the pixel input and edge output.
interface gef_pix_if
	import gef_pkg::*;
;
	logic                valid;
	logic                ready;
	logic                mode;
	logic [IN_PIX_W-1:0] pixel_value;

	modport source (output valid, mode, pixel_value, input ready);
	modport sink   (input valid, mode, pixel_value, output ready);
endinterface

interface gef_edge_if
	import gef_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [EDGE_W-1:0] edge_value;
	logic              frame_last;

	modport source (output valid, edge_value, frame_last, input ready);
	modport sink   (input valid, edge_value, frame_last, output ready);
endinterface

FILE: sv/gef_line_buf.sv
// Line buffer RAM: one write port, one registered read port.
module gef_line_buf
	import gef_pkg::*;
#(
	parameter int DEPTH  = DEF_MAX_WIDTH,
	parameter int DATA_W = 2 * DEF_PIXEL_BITS,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: sv/gef_kernel.sv
// Prewitt-style 3x3 kernel: signed difference of two triple sums, abs, clamp.
module gef_kernel
	import gef_pkg::*;
#(
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic [5:0][PIXEL_BITS-1:0] win,   // two older columns: 0..2 oldest, 3..5 newer
	input  logic [PIXEL_BITS-1:0]      top,
	input  logic [PIXEL_BITS-1:0]      mid,
	input  logic [PIXEL_BITS-1:0]      px,
	input  logic                       dir,
	input  gef_ctrl_t                  ctrl,
	output logic [EDGE_W-1:0]          edge_value
);

	localparam int SUM_W = PIXEL_BITS + 2;
	localparam int MAG_W = (SUM_W > EDGE_W + 1) ? SUM_W : EDGE_W + 1;

	logic [SUM_W-1:0]        sum_p;
	logic [SUM_W-1:0]        sum_n;
	logic signed [SUM_W:0]   diff;
	logic [SUM_W-1:0]        abs_v;
	logic [MAG_W-1:0]        mag;

	always_comb begin
		if (dir == DIR_HORIZ) begin
			// bottom row minus top row
			sum_p = SUM_W'(win[2]) + SUM_W'(win[5]) + SUM_W'(px);
			sum_n = SUM_W'(win[0]) + SUM_W'(win[3]) + SUM_W'(top);
		end else begin
			// right column minus left column
			sum_p = SUM_W'(top) + SUM_W'(mid) + SUM_W'(px);
			sum_n = SUM_W'(win[0]) + SUM_W'(win[1]) + SUM_W'(win[2]);
		end
		diff  = $signed({1'b0, sum_p}) - $signed({1'b0, sum_n});
		abs_v = diff[SUM_W] ? SUM_W'(-diff) : diff[SUM_W-1:0];
		mag   = MAG_W'(abs_v);
		if (ctrl.flush || ctrl.border) begin
			edge_value = '0;
		end else if (mag > MAG_W'(EDGE_MAX)) begin
			edge_value = EDGE_W'(EDGE_MAX);
		end else begin
			edge_value = mag[EDGE_W-1:0];
		end
	end

endmodule

FILE: sv/gradient_edge_filter_3x3.sv
// Top level of the 3x3 gradient edge filter: counters, line buffer, window, output stage.
// Throughput: one item per cycle unless edge_out stalls the pipe; the line buffer read
//   and write sit in different stages. A transferred item passes through stage 1, which
//   holds the line buffer read, then the output register, from which the result leaves.
// Results lag the pixel stream by image_width+1 positions; flush items drain the tail.
// Reset: config registers go to 640/480/vertical, counters and window to zero;
//   the line buffer is not cleared (unwritten entries feed only zeroed border results).
module gradient_edge_filter_3x3
	import gef_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	gef_pix_if.sink              pix_in,
	gef_edge_if.source           edge_out
);

	localparam int ADDR_W = $clog2(MAX_WIDTH);
	localparam int COL_W  = $clog2(MAX_WIDTH + 1);
	// compare width: holds the raw register and the column count
	localparam int CMP_W  = (COL_W > CFG_W) ? COL_W : CFG_W;
	// output counter width: holds width * height
	localparam int TOT_W  = CMP_W + ROW_W;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [CFG_W-1:0] img_w_q;
	logic [CFG_W-1:0] img_h_q;
	logic             dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= RST_IMAGE_WIDTH;
			img_h_q <= RST_IMAGE_HEIGHT;
			dir_q   <= DIR_VERT;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_IMAGE_WIDTH:    img_w_q <= cfg_wdata;
				CFG_IMAGE_HEIGHT:   img_h_q <= cfg_wdata;
				CFG_EDGE_DIRECTION: dir_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Effective frame size, clamped to the legal range
	logic [CMP_W-1:0] w_raw;
	logic [CMP_W-1:0] eff_w;
	logic [ROW_W-1:0] h_raw;
	logic [ROW_W-1:0] eff_h;

	always_comb begin
		w_raw = CMP_W'(img_w_q);
		if (w_raw < CMP_W'(MIN_SIZE)) begin
			eff_w = CMP_W'(MIN_SIZE);
		end else if (w_raw > CMP_W'(MAX_WIDTH)) begin
			eff_w = CMP_W'(MAX_WIDTH);
		end else begin
			eff_w = w_raw;
		end
		h_raw = img_h_q[ROW_W-1:0];
		if (img_h_q < CFG_W'(MIN_SIZE)) begin
			eff_h = ROW_W'(MIN_SIZE);
		end else if (img_h_q > CFG_W'(MAX_HEIGHT)) begin
			eff_h = ROW_W'(MAX_HEIGHT);
		end else begin
			eff_h = h_raw;
		end
	end

	// ---------------------------------------------------------------
	// Stage 0: transfer, position counters, emit decision
	// ---------------------------------------------------------------
	logic             out_vld_q;
	logic             adv;        // whole pipe moves this cycle
	logic             acc;        // input transfer
	logic             is_flush;
	logic             full;       // all pixels of the frame received
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [TOT_W-1:0] out_idx_q;  // results handed out in this frame
	logic [TOT_W-1:0] total;
	logic [CMP_W-1:0] col_x;
	logic             row_end;
	logic             flush_last;
	logic             emit;
	logic             border;

	// Output register is free or drains this cycle
	assign adv          = !out_vld_q || edge_out.ready;
	assign pix_in.ready = adv;
	assign acc          = pix_in.valid && adv;
	assign is_flush     = (pix_in.mode == MODE_FLUSH);
	assign full         = (row_q >= eff_h);
	assign col_x        = CMP_W'(col_q);
	assign row_end      = (col_x + CMP_W'(1)) >= eff_w;
	// frame ends on the flush that brings the result count to width*height;
	// a height cut below the current row ends it on the first flush
	assign total        = TOT_W'(eff_w) * TOT_W'(eff_h);
	assign flush_last   = (out_idx_q + TOT_W'(1)) >= total;
	// first result comes at position width+1; the row 0 term covers a width cut mid-row
	assign emit         = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && col_q != '0) ||
	                      (row_q == '0 && col_x >= eff_w + CMP_W'(1));
	assign border       = (row_q < ROW_W'(2)) || (col_q < COL_W'(2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			out_idx_q <= '0;
		end else if (acc) begin
			if (is_flush) begin
				if (full) begin
					if (flush_last) begin
						row_q     <= '0;
						col_q     <= '0;
						out_idx_q <= '0;
					end else begin
						out_idx_q <= out_idx_q + TOT_W'(1);
					end
				end
			end else if (!full) begin
				if (emit) begin
					out_idx_q <= out_idx_q + TOT_W'(1);
				end
				if (row_end) begin
					col_q <= '0;
					row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: line buffer data arrives, window update, kernel
	// ---------------------------------------------------------------
	logic                  vld_s1;
	logic                  emit_s1;
	logic                  last_s1;
	gef_ctrl_t             ctrl_s1;
	logic [PIXEL_BITS-1:0] px_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic [PIXEL_BITS-1:0] px_in;

	// low PIXEL_BITS of the input pixel, zero-extended when wider
	assign px_in = PIXEL_BITS'(pix_in.pixel_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			// pixels after a full frame and early flushes are dropped here
			vld_s1 <= acc && (is_flush ? full : !full);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			emit_s1        <= is_flush || emit;
			last_s1        <= is_flush && flush_last;
			ctrl_s1.flush  <= is_flush;
			ctrl_s1.border <= border;
			px_s1          <= px_in;
			addr_s1        <= col_q[ADDR_W-1:0];
		end
	end

	// Line buffer word: {row-2 pixel, row-1 pixel} per column.
	// Consecutive pixels hit different columns, so read and write never collide.
	logic [2*PIXEL_BITS-1:0] lb_rd;
	logic [PIXEL_BITS-1:0]   top_s1;
	logic [PIXEL_BITS-1:0]   mid_s1;
	logic                    lb_we;

	assign top_s1 = lb_rd[2*PIXEL_BITS-1:PIXEL_BITS];
	assign mid_s1 = lb_rd[PIXEL_BITS-1:0];
	assign lb_we  = adv && vld_s1 && !ctrl_s1.flush;

	gef_line_buf #(
		.DEPTH  (MAX_WIDTH),
		.DATA_W (2 * PIXEL_BITS)
	) u_line_buf (
		.clk     (clk),
		.rd_en   (adv),
		.rd_addr (col_q[ADDR_W-1:0]),
		.rd_data (lb_rd),
		.wr_en   (lb_we),
		.wr_addr (addr_s1),
		.wr_data ({mid_s1, px_s1})
	);

	// Window: two previous columns of the 3x3 neighborhood
	logic [5:0][PIXEL_BITS-1:0] win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (lb_we) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_s1;
			win_q[4] <= mid_s1;
			win_q[5] <= px_s1;
		end
	end

	logic [EDGE_W-1:0] edge_s1;

	gef_kernel #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_kernel (
		.win        (win_q),
		.top        (top_s1),
		.mid        (mid_s1),
		.px         (px_s1),
		.dir        (dir_q),
		.ctrl       (ctrl_s1),
		.edge_value (edge_s1)
	);

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	logic [EDGE_W-1:0] edge_q;
	logic              last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			edge_q <= edge_s1;
			last_q <= last_s1;
		end
	end

	assign edge_out.valid      = out_vld_q;
	assign edge_out.edge_value = edge_q;
	assign edge_out.frame_last = last_q;

endmodule

FILE: tb/sv/gef_edge_checker_pkg.sv
// Scoreboard for the 3x3 gradient edge filter: predicts each edge pixel and checks the output stream.
`timescale 1ns / 1ps
package gef_edge_checker_pkg;
	import gef_pkg::*;

	localparam int MAX_REPORTS = 100;

	typedef struct packed {
		logic [EDGE_W-1:0] edge_value;
		logic              frame_last;
	} edge_result_t;

	class edge_checker;
		logic [CFG_W-1:0]    width_reg;
		logic [CFG_W-1:0]    height_reg;
		edge_dir_t           dir_reg;
		logic [IN_PIX_W-1:0] upper_row [DEF_MAX_WIDTH];
		logic [IN_PIX_W-1:0] middle_row [DEF_MAX_WIDTH];
		logic [IN_PIX_W-1:0] win [6];
		int unsigned         row;
		int unsigned         col;
		int unsigned         out_count;
		edge_result_t        edges_due [$];
		int                  errors;
		int                  edges_seen;

		function new();
			width_reg  = RST_IMAGE_WIDTH;
			height_reg = RST_IMAGE_HEIGHT;
			dir_reg    = DIR_VERT;
			foreach (upper_row[i]) begin
				upper_row[i]  = '0;
				middle_row[i] = '0;
			end
			foreach (win[i])
				win[i] = '0;
			row        = 0;
			col        = 0;
			out_count  = 0;
			errors     = 0;
			edges_seen = 0;
		endfunction

		function int unsigned eff_width();
			if (width_reg < MIN_SIZE)
				return MIN_SIZE;
			if (width_reg > DEF_MAX_WIDTH)
				return DEF_MAX_WIDTH;
			return width_reg;
		endfunction

		function int unsigned eff_height();
			if (height_reg < MIN_SIZE)
				return MIN_SIZE;
			if (height_reg > MAX_HEIGHT)
				return MAX_HEIGHT;
			return height_reg;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			case (idx)
				CFG_IMAGE_WIDTH: begin
					width_reg = value;
				end
				CFG_IMAGE_HEIGHT: begin
					height_reg = value;
				end
				CFG_EDGE_DIRECTION: begin
					dir_reg = edge_dir_t'(value[0]);
				end
				default: begin
				end
			endcase
		endfunction

		// Appends one predicted edge pixel to the tail of the pending list.
		function void queue_edge(logic [EDGE_W-1:0] value, logic last);
			edge_result_t entry;
			entry.edge_value = value;
			entry.frame_last = last;
			edges_due = {edges_due, entry};
		endfunction

		// One accepted input transfer; queues the edge pixel it releases, if any.
		function void note_item(item_mode_t mode, logic [IN_PIX_W-1:0] px);
			int unsigned         w;
			int unsigned         h;
			int unsigned         c;
			int unsigned         val;
			int                  s;
			logic [IN_PIX_W-1:0] top;
			logic [IN_PIX_W-1:0] mid;
			w = eff_width();
			h = eff_height();
			if (mode == MODE_FLUSH) begin
				if (row < h)
					return;
				if (out_count + 1 >= w * h) begin
					queue_edge('0, 1'b1);
					row       = 0;
					col       = 0;
					out_count = 0;
				end else begin
					queue_edge('0, 1'b0);
					out_count++;
				end
				return;
			end
			if (row >= h)
				return;
			c   = col & (DEF_MAX_WIDTH - 1);
			top = upper_row[c];
			mid = middle_row[c];
			if (row * w + col >= w + 1) begin
				val = 0;
				if (row >= 2 && col >= 2) begin
					if (dir_reg == DIR_HORIZ)
						s = int'(win[2]) + int'(win[5]) + int'(px)
						  - int'(win[0]) - int'(win[3]) - int'(top);
					else
						s = int'(top) + int'(mid) + int'(px)
						  - int'(win[0]) - int'(win[1]) - int'(win[2]);
					if (s < 0)
						s = -s;
					val = (s > EDGE_MAX) ? EDGE_MAX : s;
				end
				queue_edge(EDGE_W'(val), 1'b0);
				out_count++;
			end
			win[0] = win[3];
			win[1] = win[4];
			win[2] = win[5];
			win[3] = top;
			win[4] = mid;
			win[5] = px;
			upper_row[c]  = mid;
			middle_row[c] = px;
			col++;
			if (col >= w) begin
				col = 0;
				row++;
			end
		endfunction

		task report(string what);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_edge(logic [EDGE_W-1:0] edge_value, logic frame_last);
			edge_result_t want;
			edges_seen++;
			if (edges_due.size() == 0) begin
				report($sformatf("edge #%0d arrived with nothing pending", edges_seen));
				return;
			end
			want = edges_due.pop_front();
			if (edge_value !== want.edge_value)
				report($sformatf("edge #%0d edge_value %0d, predicted %0d",
					edges_seen, edge_value, want.edge_value));
			if (frame_last !== want.frame_last)
				report($sformatf("edge #%0d frame_last %0b, predicted %0b",
					edges_seen, frame_last, want.frame_last));
		endtask
	endclass

endpackage

FILE: tb/sv/tb_gradient_edge_filter_3x3.sv
// Testbench top for the 3x3 gradient edge filter: directed frames, random frames, size extremes.
`timescale 1ns / 1ps
module tb_gradient_edge_filter_3x3;
	import gef_pkg::*;
	import gef_edge_checker_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 9;
	localparam int MAX_GAP      = 8;
	// Margin for stage 1 and the output register to settle before any register write.
	localparam int QUIET_CYCLES = 4;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 300;
	// No frame ever goes this long without a transfer on either side.
	localparam int STALL_LIMIT  = 5000;
	localparam int RANDOM_ITEMS = 620;
	// Larger frames at the end
	localparam int WIDE_WIDTH   = 64;
	localparam int TALL_HEIGHT  = 40;
	// Index that no register answers to; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	gef_pix_if  pix_ch ();
	gef_edge_if edge_ch ();

	gradient_edge_filter_3x3 i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.pix_in    (pix_ch),
		.edge_out  (edge_ch)
	);

	edge_checker board = new();

	int stall_cycles  = 0;
	int random_items  = 0;
	bit src_calm      = 1'b0;
	bit sink_calm     = 1'b0;
	bit hold_request  = 1'b0;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Monitor: every transfer on either stream goes to the scoreboard; the
	// stall counter feeds the watchdog below.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_ch.valid && pix_ch.ready)
				board.note_item(item_mode_t'(pix_ch.mode), pix_ch.pixel_value);
			if (edge_ch.valid && edge_ch.ready)
				board.check_edge(edge_ch.edge_value, edge_ch.frame_last);
			if ((pix_ch.valid && pix_ch.ready) || (edge_ch.valid && edge_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	// Watchdog: a long stretch without any transfer means the block hung.
	initial begin
		do @(posedge clk); while (stall_cycles < STALL_LIMIT);
		$display("tb: failure");
		$finish;
	end

	// Edge sink: random back-pressure, calm stretches, and one long hold on
	// request so the window pipeline fills up and pushes back on the input.
	initial begin
		int gap;
		edge_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				edge_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
				if (gap > 0) begin
					edge_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			edge_ch.ready <= 1'b1;
			do @(posedge clk); while (!edge_ch.valid);
			if ($urandom_range(0, 39) == 0)
				sink_calm = !sink_calm;
		end
	end

	// One input transfer; valid stays high into the next call when there is
	// no gap, so back-to-back items keep the stream full.
	task automatic send_item(item_mode_t mode, logic [IN_PIX_W-1:0] px);
		int gap;
		gap = src_calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_ch.valid       <= 1'b1;
		pix_ch.mode        <= mode;
		pix_ch.pixel_value <= px;
		do @(posedge clk); while (!pix_ch.ready);
		if ($urandom_range(0, 39) == 0)
			src_calm = !src_calm;
	endtask

	// Drop valid and wait until every predicted edge has left the block,
	// plus the pipeline depth for items that release no edge.
	task automatic wait_quiet();
		pix_ch.valid <= 1'b0;
		do @(posedge clk); while (board.edges_due.size() != 0);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		wait_quiet();
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		board.set_reg(idx, value);
	endtask

	// Half fully random values, a quarter noise around a per-frame level and a
	// quarter hard black/white steps to hit the clamp.
	function automatic logic [IN_PIX_W-1:0] pick_pixel(int level);
		int v;
		case ($urandom_range(0, 3))
			0: v = $urandom_range(0, 1) ? EDGE_MAX : 0;
			1: v = level + $urandom_range(0, 12) - 6;
			default: v = $urandom_range(0, 255);
		endcase
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return IN_PIX_W'(v);
	endfunction

	// A whole frame of random pixels, then the flushes that drain its tail.
	// noise_pct sprinkles in items the block must ignore: flushes while the
	// frame is still filling, pixels once it is full. With mid_change set,
	// the direction or the height is rewritten part way through the frame.
	task automatic play_frame(int noise_pct, bit mid_change);
		int unsigned w;
		int unsigned h;
		int unsigned k;
		int unsigned outs;
		int unsigned flushes;
		int          change_at;
		int          level;
		w         = board.eff_width();
		h         = board.eff_height();
		k         = 0;
		level     = $urandom_range(0, 255);
		change_at = mid_change ? $urandom_range(1, w * h - 1) : -1;
		while (k / w < h) begin
			if (k == change_at) begin
				change_at = -1;
				if ($urandom_range(0, 1))
					write_reg(CFG_EDGE_DIRECTION, CFG_W'($urandom_range(0, 2047)));
				else begin
					// a shrink below the current row ends the pixel part at once
					write_reg(CFG_IMAGE_HEIGHT, CFG_W'($urandom_range(1, 9)));
					h = board.eff_height();
				end
				continue;
			end
			if ($urandom_range(0, 99) < noise_pct)
				send_item(MODE_FLUSH, IN_PIX_W'($urandom_range(0, 255)));
			send_item(MODE_PIXEL, pick_pixel(level));
			k++;
			random_items++;
		end
		// pixel items release an edge from position width+1 on; flushes make
		// up the rest of the frame, at least one
		outs    = (k > w) ? k - w - 1 : 0;
		flushes = (outs + 1 >= w * h) ? 1 : w * h - outs;
		repeat (flushes) begin
			if ($urandom_range(0, 99) < noise_pct)
				send_item(MODE_PIXEL, IN_PIX_W'($urandom_range(0, 255)));
			send_item(MODE_FLUSH, IN_PIX_W'($urandom_range(0, 255)));
			random_items++;
		end
		// next frame has not started filling: a stray flush does nothing
		if ($urandom_range(0, 99) < noise_pct)
			send_item(MODE_FLUSH, IN_PIX_W'($urandom_range(0, 255)));
	endtask

	initial begin
		logic [IN_PIX_W-1:0] vert_frame [9];
		logic [IN_PIX_W-1:0] horiz_frame [9];
		int frame_no;

		// vertical edges, left column 10/20/30 against a zero right column:
		// negative sum below the clamp; the bright middle column must not count
		vert_frame  = '{10, 255, 0, 20, 255, 0, 30, 255, 0};
		// horizontal edges, black top row against a white bottom row: clamps
		horiz_frame = '{0, 0, 0, 128, 77, 200, 255, 255, 255};

		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_idx      <= CFG_IMAGE_WIDTH;
		cfg_wdata    <= '0;
		pix_ch.valid       <= 1'b0;
		pix_ch.mode        <= MODE_PIXEL;
		pix_ch.pixel_value <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: smallest frame, sizes below range clamp to 3, direction
		// left at its reset value (vertical).
		write_reg(CFG_IMAGE_WIDTH, CFG_W'(0));
		write_reg(CFG_IMAGE_HEIGHT, CFG_W'(2));
		send_item(MODE_FLUSH, '0);               // frame not full yet: ignored
		foreach (vert_frame[i])
			send_item(MODE_PIXEL, vert_frame[i]);
		send_item(MODE_PIXEL, 8'hFF);            // frame already full: ignored
		repeat (4)
			send_item(MODE_FLUSH, 8'hFF);
		send_item(MODE_FLUSH, '0);               // new frame empty: ignored

		// Same frame size, horizontal edges; the unused index is written too.
		write_reg(CFG_EDGE_DIRECTION, CFG_W'(DIR_HORIZ));
		write_reg(CFG_UNUSED_IDX, '1);
		write_reg(CFG_IMAGE_WIDTH, CFG_W'(1));
		foreach (horiz_frame[i])
			send_item(MODE_PIXEL, horiz_frame[i]);
		repeat (4)
			send_item(MODE_FLUSH, '0);

		// Random frames, small sizes; one frame runs with the sink held off.
		frame_no = 0;
		while (random_items < RANDOM_ITEMS) begin
			frame_no++;
			if (frame_no == 4) begin
				write_reg(CFG_IMAGE_WIDTH, CFG_W'(8));
				write_reg(CFG_IMAGE_HEIGHT, CFG_W'(8));
				src_calm     = 1'b1;
				hold_request = 1'b1;
				play_frame(0, 1'b0);
				continue;
			end
			if ($urandom_range(0, 1))
				write_reg(CFG_IMAGE_WIDTH, CFG_W'(($urandom_range(0, 3) == 0) ?
					$urandom_range(0, 2) : ($urandom_range(0, 7) == 0) ?
					$urandom_range(11, 40) : $urandom_range(3, 10)));
			if ($urandom_range(0, 1))
				write_reg(CFG_IMAGE_HEIGHT, CFG_W'(($urandom_range(0, 3) == 0) ?
					$urandom_range(0, 2) : $urandom_range(3, 8)));
			if ($urandom_range(0, 1))
				write_reg(CFG_EDGE_DIRECTION, CFG_W'($urandom_range(0, 2047)));
			play_frame($urandom_range(0, 1) ? 0 : 10, $urandom_range(0, 4) == 0);
		end

		// Larger sizes: wider rows than the random frames use, then a taller
		// frame of the narrowest width.
		write_reg(CFG_IMAGE_WIDTH, CFG_W'(WIDE_WIDTH));
		write_reg(CFG_IMAGE_HEIGHT, CFG_W'(MIN_SIZE));
		write_reg(CFG_EDGE_DIRECTION, CFG_W'(DIR_VERT));
		play_frame(2, 1'b0);
		write_reg(CFG_IMAGE_WIDTH, CFG_W'(MIN_SIZE));
		write_reg(CFG_IMAGE_HEIGHT, CFG_W'(TALL_HEIGHT));
		write_reg(CFG_EDGE_DIRECTION, CFG_W'(DIR_HORIZ));
		play_frame(2, 1'b0);

		// Drain: everything predicted has to show up, and nothing after it.
		wait_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.edges_due.size() != 0)
			board.report($sformatf("%0d predicted edges never arrived",
				board.edges_due.size()));
		if (board.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: gradient_edge_filter_3x3.f
sv/gef_pkg.sv
sv/gef_stream_if.sv
sv/gef_line_buf.sv
sv/gef_kernel.sv
sv/gradient_edge_filter_3x3.sv
tb/sv/gef_edge_checker_pkg.sv
tb/sv/tb_gradient_edge_filter_3x3.sv
